>>> rtl/tdt_pkg.sv
package tdt_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;
    localparam logic [31:0] DEFAULT_WINDOW = 32'd3600000;
    localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_FULL    = 2'd1,
        ST_FIRED   = 2'd2,
        ST_NOT_DUE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_ADD  = 2'd0,
        K_FULL = 2'd1,
        K_TICK = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_TICK_SCAN,
        S_TICK_UPD,
        S_FINAL_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic        func;
        logic [63:0] now_ms;
        logic [31:0] period_ms;
        logic        recurring;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [3:0]  slot_id;
        logic        new_earliest;
        logic [63:0] next_wait_ms;
        logic        any_armed;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [63:0] deadline;
        logic [31:0] period;
        logic        repeat_en;
    } t_slot;

endpackage

>>> rtl/timer_deadline_table.sv
// Timer deadline table.
// Requests arrive on the input channel (i_in_valid, o_in_ready, i_in_data): an add
// request places a timer in the lowest free slot, a tick request fires every due
// timer. Results leave on the output channel (o_out_valid, i_out_ready, o_out_data);
// each request yields one result, or one result per fired timer on a tick, and the
// final result of a request carries last. The rollover window is written on the
// cfg channel, which is always ready; write it only while the block is idle.
// Slot state lives in a RAM with a registered read, scanned slot by slot.
// An add to a table with a free slot makes one scan for the earliest check before
// its result is shown. A tick makes one ordered scan per fired timer, one more that
// finds nothing (left out when sixteen fire) and a final scan for the next deadline
// before its first result. Results then follow one per cycle while the receiver
// takes them. A tick on an empty table makes no scan.
// One request is processed at a time; the next is accepted once the final result
// is in the output register, even if the receiver has not yet taken it.
// When the receiver stalls, the result is held and processing waits.
// Reset clears all slot valid bits, the previous time and the pending notice, and
// restores the default rollover window; no clearing pass is needed.
module timer_deadline_table #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tdt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tdt_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [31:0]   i_cfg_data
);

    localparam int AW = $clog2(TIMER_SLOTS);
    localparam logic [AW-1:0] LAST_IDX = AW'(TIMER_SLOTS - 1);

    tdt_pkg::t_state r_state, n_state;
    tdt_pkg::t_kind  r_kind;

    logic [TIMER_SLOTS-1:0] r_valid;
    logic [TIMER_SLOTS-1:0] r_fired;
    logic [31:0] r_window;
    logic [63:0] r_prev;
    logic        r_notified;
    logic [63:0] r_now;
    logic        r_roll;

    logic [AW-1:0] r_rd_idx, r_cmp_idx;
    logic          r_rd_act, r_cmp_act;
    logic          scan_start, scan_done;

    logic [AW-1:0] r_slot;
    logic [63:0]   r_new_dl;
    logic          r_blocked;
    logic          r_ne;
    logic          add_hit;

    logic          r_found;
    logic [AW-1:0] r_best_idx;
    logic [63:0]   r_best_dl;
    logic [31:0]   r_best_pr;
    logic          r_best_rp;

    logic          r_min_found;
    logic [63:0]   r_min_dl;

    logic [AW-1:0] r_buf [tdt_pkg::MAX_RESULTS];
    logic [tdt_pkg::CNT_W-1:0] r_cnt;
    logic [tdt_pkg::CNT_W-1:0] r_emit_k;

    logic          in_acc;
    logic          free_any;
    logic [AW-1:0] free_idx;
    logic          out_load;
    logic          emit_last;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    tdt_pkg::t_slot mem_wdata;
    tdt_pkg::t_slot mem_rdata;

    tdt_pkg::t_out r_out;
    logic          r_out_valid;
    tdt_pkg::t_out out_next;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_load    = (r_state == tdt_pkg::S_EMIT) && (!r_out_valid || i_out_ready);
    assign scan_done   = r_cmp_act && (r_cmp_idx == LAST_IDX);
    assign add_hit     = r_cmp_act && (r_state == tdt_pkg::S_ADD_SCAN) &&
                         r_valid[r_cmp_idx] && (r_cmp_idx != r_slot) &&
                         ((mem_rdata.deadline < r_new_dl) ||
                          (mem_rdata.deadline == r_new_dl && r_cmp_idx < r_slot));

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdt_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.func == tdt_pkg::FUNC_ADD) begin
                        n_state = free_any ? tdt_pkg::S_ADD_SCAN : tdt_pkg::S_EMIT;
                    end else begin
                        n_state = (|r_valid) ? tdt_pkg::S_TICK_SCAN : tdt_pkg::S_EMIT;
                    end
                end
            end
            tdt_pkg::S_ADD_SCAN: begin
                if (scan_done) n_state = tdt_pkg::S_EMIT;
            end
            tdt_pkg::S_TICK_SCAN: begin
                if (scan_done) n_state = tdt_pkg::S_TICK_UPD;
            end
            tdt_pkg::S_TICK_UPD: begin
                if (r_found && (r_cnt != tdt_pkg::CNT_W'(tdt_pkg::MAX_RESULTS - 1))) begin
                    n_state = tdt_pkg::S_TICK_SCAN;
                end else begin
                    n_state = tdt_pkg::S_FINAL_SCAN;
                end
            end
            tdt_pkg::S_FINAL_SCAN: begin
                if (scan_done) n_state = tdt_pkg::S_EMIT;
            end
            tdt_pkg::S_EMIT: begin
                if (out_load && emit_last) n_state = tdt_pkg::S_IDLE;
            end
            default: n_state = tdt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == tdt_pkg::S_IDLE);
        scan_start = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_best_idx;
        mem_wdata  = '{deadline: r_now + 64'(r_best_pr), period: r_best_pr, repeat_en: 1'b1};
        unique case (r_state)
            tdt_pkg::S_IDLE: begin
                if (in_acc && i_in_data.func == tdt_pkg::FUNC_ADD && free_any) begin
                    scan_start = 1'b1;
                    mem_we     = 1'b1;
                    mem_waddr  = free_idx;
                    mem_wdata  = '{deadline: i_in_data.now_ms + 64'(i_in_data.period_ms),
                                   period: i_in_data.period_ms,
                                   repeat_en: i_in_data.recurring};
                end
                if (in_acc && i_in_data.func == tdt_pkg::FUNC_TICK && (|r_valid)) begin
                    scan_start = 1'b1;
                end
            end
            tdt_pkg::S_TICK_UPD: begin
                scan_start = 1'b1;
                mem_we     = r_found && r_best_rp;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tdt_pkg::S_IDLE;
            r_window <= tdt_pkg::DEFAULT_WINDOW;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_window <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_act  <= 1'b0;
            r_cmp_act <= 1'b0;
        end else begin
            r_cmp_act <= r_rd_act;
            if (scan_start) begin
                r_rd_act <= 1'b1;
            end else if (r_rd_act && r_rd_idx == LAST_IDX) begin
                r_rd_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_rd_idx;
        if (scan_start) begin
            r_rd_idx <= '0;
        end else if (r_rd_act) begin
            r_rd_idx <= r_rd_idx + AW'(1);
        end
    end

    tdt_slot_ram #(
        .DEPTH (TIMER_SLOTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_prev     <= '0;
            r_notified <= 1'b0;
        end else begin
            if (in_acc && i_in_data.func == tdt_pkg::FUNC_ADD && free_any) begin
                r_valid[free_idx] <= 1'b1;
            end
            if (in_acc && i_in_data.func == tdt_pkg::FUNC_TICK) begin
                r_notified <= 1'b0;
                if (|r_valid) r_prev <= i_in_data.now_ms;
            end
            if (r_state == tdt_pkg::S_ADD_SCAN && scan_done && !r_blocked && !add_hit &&
                !r_notified) begin
                r_notified <= 1'b1;
            end
            if (r_state == tdt_pkg::S_TICK_UPD && r_found && !r_best_rp) begin
                r_valid[r_best_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now       <= i_in_data.now_ms;
            r_slot      <= free_idx;
            r_new_dl    <= i_in_data.now_ms + 64'(i_in_data.period_ms);
            r_blocked   <= 1'b0;
            r_ne        <= 1'b0;
            r_fired     <= '0;
            r_cnt       <= '0;
            r_emit_k    <= '0;
            r_min_found <= 1'b0;
            r_roll      <= (i_in_data.now_ms < r_prev) &&
                           ((r_prev - i_in_data.now_ms) > 64'(r_window));
            if (i_in_data.func == tdt_pkg::FUNC_ADD) begin
                r_kind <= free_any ? tdt_pkg::K_ADD : tdt_pkg::K_FULL;
            end else begin
                r_kind <= tdt_pkg::K_TICK;
            end
        end
        if (scan_start) begin
            r_found <= 1'b0;
        end
        if (r_cmp_act) begin
            unique case (r_state)
                tdt_pkg::S_ADD_SCAN: begin
                    if (add_hit) begin
                        r_blocked <= 1'b1;
                    end
                end
                tdt_pkg::S_TICK_SCAN: begin
                    if (r_valid[r_cmp_idx] && !r_fired[r_cmp_idx] &&
                        (r_roll || mem_rdata.deadline <= r_now) &&
                        (!r_found || mem_rdata.deadline < r_best_dl)) begin
                        r_found    <= 1'b1;
                        r_best_idx <= r_cmp_idx;
                        r_best_dl  <= mem_rdata.deadline;
                        r_best_pr  <= mem_rdata.period;
                        r_best_rp  <= mem_rdata.repeat_en;
                    end
                end
                tdt_pkg::S_FINAL_SCAN: begin
                    if (r_valid[r_cmp_idx] && (!r_min_found || mem_rdata.deadline < r_min_dl)) begin
                        r_min_found <= 1'b1;
                        r_min_dl    <= mem_rdata.deadline;
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_state == tdt_pkg::S_ADD_SCAN && scan_done) begin
            r_ne <= !r_blocked && !add_hit && !r_notified;
        end
        if (r_state == tdt_pkg::S_TICK_UPD && r_found) begin
            r_fired[r_best_idx] <= 1'b1;
            r_buf[r_cnt[3:0]]   <= r_best_idx;
            r_cnt               <= r_cnt + tdt_pkg::CNT_W'(1);
        end
        if (out_load) begin
            r_emit_k <= r_emit_k + tdt_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        emit_last = (r_kind != tdt_pkg::K_TICK) || (r_cnt == '0) ||
                    (r_emit_k == r_cnt - tdt_pkg::CNT_W'(1));
        out_next              = '0;
        out_next.any_armed    = |r_valid;
        out_next.last         = emit_last;
        case (r_kind)
            tdt_pkg::K_ADD: begin
                out_next.status       = tdt_pkg::ST_ADDED;
                out_next.slot_id      = 4'(r_slot);
                out_next.new_earliest = r_ne;
            end
            tdt_pkg::K_FULL: begin
                out_next.status = tdt_pkg::ST_FULL;
            end
            default: begin
                if (!r_min_found) begin
                    out_next.next_wait_ms = tdt_pkg::ALL_ONES;
                end else if (r_now >= r_min_dl) begin
                    out_next.next_wait_ms = '0;
                end else begin
                    out_next.next_wait_ms = r_min_dl - r_now;
                end
                if (r_cnt == '0) begin
                    out_next.status = tdt_pkg::ST_NOT_DUE;
                end else begin
                    out_next.status  = tdt_pkg::ST_FIRED;
                    out_next.slot_id = 4'(r_buf[r_emit_k[3:0]]);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= out_next;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != tdt_pkg::S_IDLE |-> r_cnt <= tdt_pkg::CNT_W'(tdt_pkg::MAX_RESULTS))
        else $error("fired count exceeds result limit");

    a_upd_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && r_state == tdt_pkg::S_TICK_UPD |-> r_found && r_best_rp)
        else $error("slot rewritten without a fired recurring timer");

    a_add_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == tdt_pkg::ST_ADDED |-> r_out.any_armed)
        else $error("add result reports an empty table");

endmodule

>>> rtl/tdt_slot_ram.sv
module tdt_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  tdt_pkg::t_slot i_wdata,
    input  logic [AW-1:0] i_raddr,
    output tdt_pkg::t_slot o_rdata
);

    tdt_pkg::t_slot r_mem [DEPTH];
    tdt_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
